// ===== rtl/core/sckd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sckd_pkg: shared types, constants and the layout translation function
// Holds scancode values, modifier bit positions, the command record that
// travels from the front to the back, and the set-1 to character tables.
// ----------------------------------------------------------------------------
package sckd_pkg;

  // Stream widths and field positions
  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 24;
  localparam int unsigned CodeW    = 7;
  localparam int unsigned CharW    = 8;
  localparam int unsigned ModW     = 5;

  // Item kinds carried in the slave-side tuser
  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_READ = 1'b1
  } sckd_op_e;

  // Keyboard layouts
  typedef enum logic [1:0] {
    MAP_US  = 2'd0,
    MAP_UK  = 2'd1,
    MAP_ITA = 2'd2
  } sckd_layout_e;

  // Scancodes
  localparam logic [7:0] KeyPrefix    = 8'hE0;
  localparam logic [7:0] KeyUp        = 8'h48;
  localparam logic [7:0] KeyDown      = 8'h50;
  localparam logic [7:0] KeyT         = 8'h14;
  localparam logic [7:0] KeyTRel      = 8'h94;
  localparam logic [7:0] KeyCaps      = 8'h3A;
  localparam logic [7:0] KeyLShift    = 8'h2A;
  localparam logic [7:0] KeyLShiftRel = 8'hAA;
  localparam logic [7:0] KeyRShift    = 8'h36;
  localparam logic [7:0] KeyRShiftRel = 8'hB6;
  localparam logic [7:0] KeyLAlt      = 8'h38;
  localparam logic [7:0] KeyLAltRel   = 8'hB8;
  localparam logic [7:0] KeyLCtrl     = 8'h1D;
  localparam logic [7:0] KeyLCtrlRel  = 8'h9D;

  // Modifier bit positions
  localparam int unsigned ModLShift = 0;
  localparam int unsigned ModRShift = 1;
  localparam int unsigned ModLAlt   = 2;
  localparam int unsigned ModLCtrl  = 3;
  localparam int unsigned ModCaps   = 4;

  // Scroll request codes (two's complement)
  localparam logic [1:0] ScrollNone = 2'b00;
  localparam logic [1:0] ScrollUp   = 2'b01;
  localparam logic [1:0] ScrollDown = 2'b11;

  // Front-to-back queue
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW      = $clog2(QueueDepth);
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

  // One decoded item on its way to the back
  typedef struct packed {
    logic [1:0]       scroll;
    logic             toggle;
    logic             valid;
    logic [CodeW-1:0] code;
    logic [ModW-1:0]  mods;
  } sckd_cmd_t;

  // Translation tables: codes at or past the table end translate to zero
  localparam int unsigned TableLen = 60;

  localparam logic [7:0] UsPlain [TableLen] = '{
    8'h00, 8'h00, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38,
    8'h39, 8'h30, 8'h2D, 8'h3D, 8'h00, 8'h00, 8'h71, 8'h77, 8'h65, 8'h72,
    8'h74, 8'h79, 8'h75, 8'h69, 8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00,
    8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
    8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E,
    8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A, 8'h00, 8'h20, 8'h00, 8'h00
  };

  localparam logic [7:0] UsShift [TableLen] = '{
    8'h00, 8'h00, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A,
    8'h28, 8'h29, 8'h5F, 8'h2B, 8'h00, 8'h00, 8'h51, 8'h57, 8'h45, 8'h52,
    8'h54, 8'h59, 8'h55, 8'h49, 8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00,
    8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
    8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E,
    8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A, 8'h00, 8'h20, 8'h00, 8'h00
  };

  // Translate a press code with the given layout and modifiers. The UK and
  // Italian layouts are the US table with their differing keys patched in.
  function automatic logic [CharW-1:0] sckd_translate(sckd_layout_e     lay,
                                                      logic [CodeW-1:0] code,
                                                      logic [ModW-1:0]  mods);
    logic [5:0]       idx;
    logic [7:0]       lo;
    logic [7:0]       hi;
    logic             shifted;
    logic             caps;
    logic [CharW-1:0] res;
    idx     = code[5:0];
    lo      = 8'h00;
    hi      = 8'h00;
    shifted = mods[ModLShift] | mods[ModRShift];
    caps    = mods[ModCaps];
    res     = 8'h00;
    if (code < CodeW'(TableLen)) begin
      lo = UsPlain[idx];
      hi = UsShift[idx];
      case (lay)
        MAP_UK: begin
          case (idx)
            6'd3:  hi = 8'h22;
            6'd4:  hi = 8'hA3;
            6'd40: hi = 8'h40;
            6'd43: begin lo = 8'h23; hi = 8'h7E; end
            default: ;
          endcase
        end
        MAP_ITA: begin
          case (idx)
            6'd3:  hi = 8'h22;
            6'd4:  hi = 8'h23;
            6'd5:  hi = 8'h24;
            6'd6:  hi = 8'h25;
            6'd7:  hi = 8'h26;
            6'd8:  hi = 8'h2F;
            6'd9:  hi = 8'h28;
            6'd10: hi = 8'h29;
            6'd11: hi = 8'h3D;
            6'd12: begin lo = 8'h27; hi = 8'h3F; end
            6'd13: begin lo = 8'h69; hi = 8'h5E; end
            6'd26: begin lo = 8'h65; hi = 8'h45; end
            6'd27: begin lo = 8'h2B; hi = 8'h2A; end
            6'd39: begin lo = 8'h6F; hi = 8'h43; end
            6'd40: begin lo = 8'h61; hi = 8'h4F; end
            6'd41: begin lo = 8'h5C; hi = 8'h7C; end
            6'd43: begin lo = 8'h75; hi = 8'h53; end
            6'd51: hi = 8'h3B;
            6'd52: hi = 8'h3A;
            6'd53: begin lo = 8'h2D; hi = 8'h5F; end
            default: ;
          endcase
        end
        default: ;
      endcase
      if (lo != 8'h00) begin
        if (hi != 8'h00 &&
            (shifted || (caps && lo >= 8'h61 && lo <= 8'h7A))) begin
          res = hi;
        end else begin
          res = lo;
        end
      end
    end
    return res;
  endfunction

endpackage

// ===== rtl/core/sckd_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sckd_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sckd_ram #(
  parameter int unsigned WIDTH = 7,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/sckd_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sckd_front: beat intake, scancode classification and key FIFO
// Tracks modifiers, the extended prefix and the T key, pushes presses into
// the key store and pops it on reads; emits one command record per beat.
// ----------------------------------------------------------------------------
module sckd_front
  import sckd_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  sckd_op_e     in_op_i,
  input  logic [7:0]   in_byte_i,
  input  logic         in_gfx_i,
  output logic         cmd_valid_o,
  input  logic         cmd_ready_i,
  output sckd_cmd_t    cmd_o
);

  localparam int unsigned PtrW = $clog2(FIFO_DEPTH);

  logic            accept;
  logic            s1_valid_q;
  logic [1:0]      scroll_d, scroll_q;
  logic            toggle_d, toggle_q;
  logic            rvalid_d, rvalid_q;
  logic [ModW-1:0] mods_d, mods_q;
  logic            prefix_d, prefix_q;
  logic            t_held_d, t_held_q;
  logic [PtrW-1:0] wr_d, wr_q;
  logic [PtrW-1:0] rd_d, rd_q;
  logic [PtrW-1:0] wr_next;
  logic [PtrW-1:0] rd_next;
  logic            push;
  logic            pop;
  logic            fifo_full;
  logic            fifo_empty;
  logic [CodeW-1:0] rdata;

  assign in_ready_o = !s1_valid_q || cmd_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // Pointer wrap and FIFO status
  assign wr_next    = (wr_q == PtrW'(FIFO_DEPTH - 1)) ? '0 : wr_q + 1'b1;
  assign rd_next    = (rd_q == PtrW'(FIFO_DEPTH - 1)) ? '0 : rd_q + 1'b1;
  assign fifo_full  = (wr_next == rd_q);
  assign fifo_empty = (wr_q == rd_q);

  // Classify the beat and update tracking state
  always_comb begin
    mods_d   = mods_q;
    prefix_d = prefix_q;
    t_held_d = t_held_q;
    wr_d     = wr_q;
    rd_d     = rd_q;
    push     = 1'b0;
    pop      = 1'b0;
    scroll_d = ScrollNone;
    toggle_d = 1'b0;
    rvalid_d = 1'b0;
    if (accept) begin
      if (in_op_i == OP_BYTE) begin
        if (in_byte_i == KeyPrefix) begin
          prefix_d = 1'b1;
        end else begin
          unique case (in_byte_i)
            KeyLShift:    mods_d[ModLShift] = 1'b1;
            KeyLShiftRel: mods_d[ModLShift] = 1'b0;
            KeyRShift:    mods_d[ModRShift] = 1'b1;
            KeyRShiftRel: mods_d[ModRShift] = 1'b0;
            KeyLAlt:      mods_d[ModLAlt]   = 1'b1;
            KeyLAltRel:   mods_d[ModLAlt]   = 1'b0;
            KeyLCtrl:     mods_d[ModLCtrl]  = 1'b1;
            KeyLCtrlRel:  mods_d[ModLCtrl]  = 1'b0;
            KeyCaps:      mods_d[ModCaps]   = !mods_q[ModCaps];
            default: ;
          endcase
          if (prefix_q) begin
            // Extended byte: consume, scroll on arrows in text mode
            prefix_d = 1'b0;
            if (!in_gfx_i) begin
              if (in_byte_i == KeyUp) begin
                scroll_d = ScrollUp;
              end else if (in_byte_i == KeyDown) begin
                scroll_d = ScrollDown;
              end
            end
          end else if (in_byte_i == KeyT) begin
            toggle_d = !t_held_q && mods_d[ModLCtrl];
            t_held_d = 1'b1;
          end else if (in_byte_i == KeyTRel) begin
            t_held_d = 1'b0;
          end else if (!in_byte_i[7] && !fifo_full) begin
            push = 1'b1;
            wr_d = wr_next;
          end
        end
      end else if (!fifo_empty) begin
        pop      = 1'b1;
        rd_d     = rd_next;
        rvalid_d = 1'b1;
      end
    end
  end

  // Tracking state and stage-one valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      mods_q     <= '0;
      prefix_q   <= 1'b0;
      t_held_q   <= 1'b0;
      wr_q       <= '0;
      rd_q       <= '0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (cmd_ready_i) begin
        s1_valid_q <= 1'b0;
      end
      mods_q   <= mods_d;
      prefix_q <= prefix_d;
      t_held_q <= t_held_d;
      wr_q     <= wr_d;
      rd_q     <= rd_d;
    end
  end

  // Stage-one payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      scroll_q <= scroll_d;
      toggle_q <= toggle_d;
      rvalid_q <= rvalid_d;
    end
  end

  // Key store; read data lands together with the stage-one record
  sckd_ram #(
    .WIDTH (CodeW),
    .DEPTH (FIFO_DEPTH)
  ) u_key_store (
    .clk_i   (clk_i),
    .we_i    (push),
    .waddr_i (wr_q),
    .wdata_i (in_byte_i[CodeW-1:0]),
    .re_i    (pop),
    .raddr_i (rd_q),
    .rdata_o (rdata)
  );

  // Command record; modifiers shown are those after the beat
  always_comb begin
    cmd_o.scroll = scroll_q;
    cmd_o.toggle = toggle_q;
    cmd_o.valid  = rvalid_q;
    cmd_o.code   = rvalid_q ? rdata : '0;
    cmd_o.mods   = mods_q;
  end

  assign cmd_valid_o = s1_valid_q;

endmodule

// ===== rtl/core/sckd_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sckd_queue: short command queue between front and back
// A two-entry register queue so that either side can stall on its own.
// ----------------------------------------------------------------------------
module sckd_queue
  import sckd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  sckd_cmd_t in_cmd_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output sckd_cmd_t out_cmd_o
);

  sckd_cmd_t        entry_q [QueueDepth];
  logic [QPtrW-1:0] wr_q;
  logic [QPtrW-1:0] rd_q;
  logic [QCntW-1:0] cnt_q;
  logic             push;
  logic             pop;

  assign in_ready_o  = (cnt_q != QCntW'(QueueDepth));
  assign out_valid_o = (cnt_q != '0);
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;
  assign out_cmd_o   = entry_q[rd_q];

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_q] <= in_cmd_i;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == QPtrW'(QueueDepth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop) begin
        rd_q <= (rd_q == QPtrW'(QueueDepth - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/sckd_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sckd_back: character translation and result register
// Holds the layout register, translates popped codes and presents one
// result beat on the master side.
// ----------------------------------------------------------------------------
module sckd_back
  import sckd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  sckd_cmd_t           in_cmd_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [OutDataW-1:0] out_data_o,
  output logic                out_user_o
);

  sckd_layout_e     layout_q;
  logic             out_valid_q;
  sckd_cmd_t        res_q;
  logic [CharW-1:0] char_q;
  logic [CharW-1:0] char_d;
  logic             take;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign take       = in_valid_i && in_ready_o;

  // Translate the popped code; a zero code on a non-read is gated off
  always_comb begin
    char_d = '0;
    if (in_cmd_i.valid) begin
      char_d = sckd_translate(layout_q, in_cmd_i.code, in_cmd_i.mods);
    end
  end

  // Layout register and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      layout_q    <= MAP_US;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i && cfg_wdata_i <= MAP_ITA) begin
        layout_q <= sckd_layout_e'(cfg_wdata_i);
      end
      if (take) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (take) begin
      res_q  <= in_cmd_i;
      char_q <= char_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_user_o  = res_q.valid;
  assign out_data_o  = {1'b0, res_q.mods, char_q, res_q.code, res_q.toggle, res_q.scroll};

endmodule

// ===== rtl/core/scancode_keyboard_decoder_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scancode_keyboard_decoder_top: set-1 scancode decoder with key FIFO
// Decodes keyboard bytes into modifier, scroll and toggle events, buffers
// presses and returns translated characters on reads.
//
//   Channel   Dir  Fields (low bit up)
//   s_axis    in   tdata: key_byte[7:0], graphics_active[8], zero[15:9]
//                  tuser: opcode (0 byte, 1 read)
//   m_axis    out  tdata: scroll_request[1:0], toggle_request[2],
//                  read_code[9:3], read_char[17:10], modifier_state[22:18]
//                  tuser: read_valid
//   cfg       in   cfg_wdata: layout_select, written when cfg_we is high and <= 2
//
// One beat per cycle in each direction while neither side stalls; the result of
// a beat passes the front stage register, then a queue entry, then the result
// register before it is offered on m_axis.
// The key store is a registered-read RAM; its read data lines up with the
// front stage register.
// A two-entry queue parts front and back; s_axis stays ready while the
// queue has room, even when a result waits on m_axis.
// Reset is asynchronous and takes effect at once; the key store is not
// cleared, since only written entries are ever read.
// ----------------------------------------------------------------------------
module scancode_keyboard_decoder_top
  import sckd_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_wdata_i,     // layout_select
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [InDataW-1:0]  s_axis_tdata_i,  // key_byte, graphics_active
  input  logic                s_axis_tuser_i,  // opcode
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [OutDataW-1:0] m_axis_tdata_o,  // scroll, toggle, code, char, mods
  output logic                m_axis_tuser_o   // read_valid
);

  logic      cmd_valid;
  logic      cmd_ready;
  sckd_cmd_t cmd;
  logic      q_valid;
  logic      q_ready;
  sckd_cmd_t q_cmd;

  // Front: intake and classification
  sckd_front #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_op_i     (sckd_op_e'(s_axis_tuser_i)),
    .in_byte_i   (s_axis_tdata_i[7:0]),
    .in_gfx_i    (s_axis_tdata_i[8]),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  // Decoupling queue
  sckd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (cmd_valid),
    .in_ready_o  (cmd_ready),
    .in_cmd_i    (cmd),
    .out_valid_o (q_valid),
    .out_ready_i (q_ready),
    .out_cmd_o   (q_cmd)
  );

  // Back: translation and result register
  sckd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (q_valid),
    .in_ready_o  (q_ready),
    .in_cmd_i    (q_cmd),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o),
    .out_user_o  (m_axis_tuser_o)
  );

`ifndef NO_ASSERTIONS
  // A result that popped nothing carries no code and no character
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o |->
      m_axis_tdata_o[9:3] == '0 && m_axis_tdata_o[17:10] == '0)
    else $error("empty result carries code or character");

  // A read result never carries scroll or toggle events
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |->
      m_axis_tdata_o[1:0] == ScrollNone && !m_axis_tdata_o[2])
    else $error("read result carries byte events");

  // A toggle pulse and a scroll request never share a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[2] |-> m_axis_tdata_o[1:0] == ScrollNone)
    else $error("toggle and scroll in one result");

  // A front record that is not taken is still offered in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid && !cmd_ready |=> cmd_valid && $stable(cmd))
    else $error("front record lost under queue stall");
`endif

endmodule
